[hdl/bmc_pkg.sv]
// shared types and constants for the circular binary morphology block
`default_nettype none

package bmc_pkg;

  // field and port widths
  localparam int FLEN_W     = 7;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // default frame capacity and structuring element divisor
  localparam int MAX_FRAME_DEF = 64;
  localparam int SE_DIVISOR    = 10;

  // register reset values
  localparam logic [FLEN_W-1:0] FLEN_RESET = 7'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd1;

  // morphology operation
  typedef enum logic [MODE_W-1:0] {
    MODE_DILATE,
    MODE_ERODE,
    MODE_CLOSE,
    MODE_OPEN
  } mode_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS1,
    ST_COPY,
    ST_FINAL
  } state_t;

  // frame store controls from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rot_en;
    logic copy_en;
  } store_ctrl_t;

endpackage

`default_nettype wire

[hdl/bmc_pix_if.sv]
// input channel: one frame bit per transaction
`default_nettype none

interface bmc_pix_if;
  logic valid;
  logic ready;
  logic pixel_bit;

  modport source (output valid, output pixel_bit, input ready);
  modport sink (input valid, input pixel_bit, output ready);
endinterface

`default_nettype wire

[hdl/bmc_res_if.sv]
// output channel: one result bit per transaction
`default_nettype none

interface bmc_res_if;
  logic valid;
  logic ready;
  logic result_bit;
  logic result_last;

  modport source (output valid, output result_bit, output result_last, input ready);
  modport sink (input valid, input result_bit, input result_last, output ready);
endinterface

`default_nettype wire

[hdl/bmc_rot_store.sv]
// frame store with indexed load, whole-frame copy and circular rotation over the frame length
`default_nettype none

module bmc_rot_store #(
  parameter int MAX_FRAME = bmc_pkg::MAX_FRAME_DEF,
  parameter int MAX_W     = MAX_FRAME / bmc_pkg::SE_DIVISOR
) (
  input  wire                               clk,
  input  wire bmc_pkg::store_ctrl_t         ctrl,
  input  wire [$clog2(MAX_FRAME)-1:0]       wr_idx,
  input  wire                               wr_bit,
  input  wire [$clog2(MAX_FRAME+1)-1:0]     len,
  input  wire [MAX_FRAME-1:0]               copy_data,
  output logic [MAX_W-1:0]                  taps
);

  localparam int LW = $clog2(MAX_FRAME + 1);

  logic [MAX_FRAME-1:0] fr;
  logic [MAX_FRAME-1:0] rot;

  // rotate by one position within the first len bits
  always_comb begin
    rot = {fr[0], fr[MAX_FRAME-1:1]};
    for (int i = 0; i < MAX_FRAME; i++) begin
      if (LW'(i) + LW'(1) == len) begin
        rot[i] = fr[0];
      end
    end
  end

  // store update
  always_ff @(posedge clk) begin
    if (ctrl.copy_en) begin
      fr <= copy_data;
    end else if (ctrl.rot_en) begin
      fr <= rot;
    end else if (ctrl.wr_en) begin
      fr[wr_idx] <= wr_bit;
    end
  end

  // window taps at the head of the rotation
  assign taps = fr[MAX_W-1:0];

endmodule

`default_nettype wire

[hdl/bmc_win_unit.sv]
// shared window unit: masked or/and over the structuring element taps
`default_nettype none

module bmc_win_unit #(
  parameter int MAX_FRAME = bmc_pkg::MAX_FRAME_DEF,
  parameter int MAX_W     = MAX_FRAME / bmc_pkg::SE_DIVISOR
) (
  input  wire [MAX_W-1:0]                taps,
  input  wire [$clog2(MAX_FRAME+1)-1:0]  len,
  input  wire                            is_dilate,
  output logic                           r
);

  localparam int LW = $clog2(MAX_FRAME + 1);
  localparam int WW = $clog2(MAX_W + 1);

  logic [WW-1:0]    w;
  logic [MAX_W-1:0] mask;

  // element width is floor(len / divisor), found by threshold compares
  always_comb begin
    w = '0;
    for (int k = 1; k <= MAX_W; k++) begin
      if (len >= LW'(k * bmc_pkg::SE_DIVISOR)) begin
        w = w + WW'(1);
      end
    end
  end

  // taps inside the element
  always_comb begin
    for (int j = 0; j < MAX_W; j++) begin
      mask[j] = (WW'(j) < w);
    end
  end

  // empty element gives 0 for dilation and 1 for erosion
  assign r = is_dilate ? |(taps & mask) : &(taps | ~mask);

endmodule

`default_nettype wire

[hdl/binary_morphology_1d_circular_top.sv]
// top level: frame loading, pass sequencer and result output register
`default_nettype none

// Takes a binary frame one bit per transaction on pix. When the last bit
// of a frame arrives (frame_length, saturated to 1..MAX_FRAME, bits), the
// block stops taking input and runs the shared window unit over a rotating
// frame store, one frame position per cycle unless res stalls: dilation or
// erosion takes one pass; closing or opening takes a first pass into a pass
// store, a copy back and a second pass. Results of the last pass leave on
// res one per cycle through an output register, the final bit marked by
// result_last; a stalled res holds the sequencer. For a frame of L bits
// the element width is floor(L/10) and the window looks forward from each
// position, wrapping round the frame. Configuration is to be written while
// the block is idle; the block itself does not enforce this.

module binary_morphology_1d_circular_top #(
  parameter int MAX_FRAME = bmc_pkg::MAX_FRAME_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  bmc_pix_if.sink                          pix,
  bmc_res_if.source                        res,
  input  wire                              cfg_we,
  input  wire [bmc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire [bmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW    = $clog2(MAX_FRAME);
  localparam int LW    = $clog2(MAX_FRAME + 1);
  localparam int FW    = bmc_pkg::FLEN_W;
  localparam int MAX_W = MAX_FRAME / bmc_pkg::SE_DIVISOR;

  bmc_pkg::state_t      state;
  bmc_pkg::state_t      state_next;
  bmc_pkg::store_ctrl_t ctrl;
  bmc_pkg::mode_t       mode;
  bmc_pkg::mode_t       mode_q;
  logic [FW-1:0]        frame_length;
  logic [LW-1:0]        len_eff;
  logic [LW-1:0]        len_q;
  logic [IW-1:0]        load_count;
  logic [IW-1:0]        pos;
  logic [MAX_FRAME-1:0] ps;
  logic [MAX_W-1:0]     taps;
  logic                 is_dilate;
  logic                 r;
  logic                 in_rdy;
  logic                 pix_acc;
  logic                 frame_end;
  logic                 two_pass;
  logic                 adv;
  logic                 pos_last;
  logic                 out_vld;
  logic                 out_bit;
  logic                 out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= bmc_pkg::MODE_DILATE;
      frame_length <= bmc_pkg::FLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        bmc_pkg::REG_MODE: begin
          mode <= bmc_pkg::mode_t'(cfg_data[bmc_pkg::MODE_W-1:0]);
        end
        bmc_pkg::REG_FRAME_LENGTH: begin
          frame_length <= cfg_data[FW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective frame length, saturated to 1..MAX_FRAME
  always_comb begin
    if (frame_length == '0) begin
      len_eff = LW'(1);
    end else if (frame_length > FW'(MAX_FRAME)) begin
      len_eff = LW'(MAX_FRAME);
    end else begin
      len_eff = LW'(frame_length);
    end
  end

  assign pix_acc   = pix.valid && in_rdy;
  assign frame_end = pix_acc && (LW'(load_count) + LW'(1) >= len_eff);
  assign two_pass  = (mode == bmc_pkg::MODE_CLOSE) || (mode == bmc_pkg::MODE_OPEN);
  assign adv       = (state == bmc_pkg::ST_FINAL) && (!out_vld || res.ready);
  assign pos_last  = (LW'(pos) + LW'(1) == len_q);

  // or for dilation passes, and for erosion passes
  always_comb begin
    if (state == bmc_pkg::ST_FINAL) begin
      is_dilate = (mode_q == bmc_pkg::MODE_DILATE) || (mode_q == bmc_pkg::MODE_OPEN);
    end else begin
      is_dilate = (mode_q == bmc_pkg::MODE_CLOSE);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmc_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state and store controls
  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_rdy     = 1'b0;
    case (state)
      bmc_pkg::ST_LOAD: begin
        in_rdy     = 1'b1;
        ctrl.wr_en = pix_acc;
        if (frame_end) begin
          state_next = two_pass ? bmc_pkg::ST_PASS1 : bmc_pkg::ST_FINAL;
        end
      end
      bmc_pkg::ST_PASS1: begin
        ctrl.rot_en = 1'b1;
        if (pos_last) begin
          state_next = bmc_pkg::ST_COPY;
        end
      end
      bmc_pkg::ST_COPY: begin
        ctrl.copy_en = 1'b1;
        state_next   = bmc_pkg::ST_FINAL;
      end
      bmc_pkg::ST_FINAL: begin
        ctrl.rot_en = adv;
        if (adv && pos_last) begin
          state_next = bmc_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = bmc_pkg::ST_LOAD;
      end
    endcase
  end

  assign pix.ready = in_rdy;

  // load counter
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (pix_acc) begin
      load_count <= frame_end ? '0 : load_count + IW'(1);
    end
  end

  // frame settings held for the passes
  always_ff @(posedge clk) begin
    if (frame_end) begin
      len_q  <= len_eff;
      mode_q <= mode;
    end
  end

  // position counter over the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if ((state == bmc_pkg::ST_PASS1) || adv) begin
      pos <= pos_last ? '0 : pos + IW'(1);
    end
  end

  // first pass results
  always_ff @(posedge clk) begin
    if (state == bmc_pkg::ST_PASS1) begin
      ps[pos] <= r;
    end
  end

  bmc_rot_store #(
    .MAX_FRAME (MAX_FRAME),
    .MAX_W     (MAX_W)
  ) u_store (
    .clk       (clk),
    .ctrl      (ctrl),
    .wr_idx    (load_count),
    .wr_bit    (pix.pixel_bit),
    .len       (len_q),
    .copy_data (ps),
    .taps      (taps)
  );

  bmc_win_unit #(
    .MAX_FRAME (MAX_FRAME),
    .MAX_W     (MAX_W)
  ) u_win (
    .taps      (taps),
    .len       (len_q),
    .is_dilate (is_dilate),
    .r         (r)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bit  <= r;
      out_last <= pos_last;
    end
  end

  assign res.valid       = out_vld;
  assign res.result_bit  = out_bit;
  assign res.result_last = out_last;

`ifndef SYNTHESIS
  // copy cycle always leads into the final pass
  a_copy_to_final: assert property (@(posedge clk) disable iff (rst)
    state == bmc_pkg::ST_COPY |=> state == bmc_pkg::ST_FINAL)
    else $error("copy not followed by final pass");

  // last emitted position returns to loading with a marked result
  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    (adv && pos_last) |=> (state == bmc_pkg::ST_LOAD && res.valid && res.result_last))
    else $error("frame end not marked on output");

  // completed frame starts a pass and clears the load counter
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    frame_end |=> (load_count == '0 &&
                   (state == bmc_pkg::ST_PASS1 || state == bmc_pkg::ST_FINAL)))
    else $error("frame end did not start a pass");

  // position stays inside the frame during the passes
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (state == bmc_pkg::ST_PASS1 || state == bmc_pkg::ST_FINAL) |-> LW'(pos) < len_q)
    else $error("position beyond frame length");

  // a pending unmarked result means the final pass is still running
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.result_last) |-> state == bmc_pkg::ST_FINAL)
    else $error("unmarked result pending outside final pass");
`endif

endmodule

`default_nettype wire
